@@ sv/audio_echo_mixer_top_defines.svh @@
// assertion macros for the audio echo mixer
// used by the controller and datapath modules; no other dependencies
`ifndef AUDIO_ECHO_MIXER_TOP_DEFINES_SVH
`define AUDIO_ECHO_MIXER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define AEM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aem assertion failed");
// next-cycle implication, disabled in reset
`define AEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aem assertion failed");
`else
`define AEM_ASSERT_NOW(label, clk, rst, ante, cons)
`define AEM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/aem_pkg.sv @@
// shared constants and controller/datapath interface types for the echo mixer
// no dependencies
package aem_pkg;

  localparam int MaxDelay  = 16384;
  localparam int AddrW     = $clog2(MaxDelay);
  localparam int DelayW    = 15;
  localparam int DivW      = 16;
  localparam int SampleW   = 16;
  localparam int DivSteps  = DivW;
  localparam int StepCntW  = $clog2(DivSteps);

  localparam logic [DelayW-1:0] DelayReset   = 15'd8000;
  localparam logic [DivW-1:0]   DivisorReset = 16'd4;

  // register indexes on the configuration port
  localparam logic CfgDelay   = 1'b0;
  localparam logic CfgDivisor = 1'b1;

  // request kinds
  localparam logic ActSample = 1'b0;
  localparam logic ActTail   = 1'b1;

  typedef struct packed {
    logic capture;   // latch the incoming request, pick the read index
    logic load;      // load divider from the read data
    logic step;      // one restoring division step
    logic finish;    // write output, store entry, update pointers
    logic clear_wr;  // zero one store entry of the clearing pass
  } cmd_t;

  typedef struct packed {
    logic last;        // request in flight ends the tail
    logic out_free;    // output register can take a result
    logic clear_done;  // clearing pass is at its final entry
  } status_t;

endpackage

@@ sv/audio_echo_mixer_top.sv @@
// top level of the audio echo mixer (feedforward comb filter echo)
// depends on aem_pkg, aem_ctrl and aem_dp
//
//  channel   direction  contents
//  s_*       in         tdata[15:0] sample_in, tuser action (1 = tail request)
//  m_*       out        tdata[15:0] sample_out, tlast last tail output
//  cfg_*     in         index 0 delay_length[14:0], index 1 echo_divisor[15:0]
//
// a result is valid once its accepted request has passed store read, divider load, 16
// restoring division steps and write-back, after which the next request can be taken
// after reset, and after the last tail result, a clearing pass zeroes all
// 16384 store entries with s_tready low
// a result waiting on m_tready does not block acceptance of the next request;
// write-back stalls only if the previous result is still unread

module audio_echo_mixer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [aem_pkg::SampleW-1:0] s_tdata,   // [15:0] sample_in
  input  logic                        s_tuser,   // [0] action
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [aem_pkg::SampleW-1:0] m_tdata,   // [15:0] sample_out
  output logic                        m_tlast,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [aem_pkg::DivW-1:0]    cfg_data
);

  aem_pkg::cmd_t    cmd;
  aem_pkg::status_t status;

  aem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  aem_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

@@ sv/aem_ctrl.sv @@
// controller state machine for the echo mixer
// depends on aem_pkg and audio_echo_mixer_top_defines.svh
`include "audio_echo_mixer_top_defines.svh"

module aem_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  aem_pkg::status_t status,
  output aem_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t                         state;
  logic [aem_pkg::StepCntW-1:0]   step_cnt;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR:  cmd.clear_wr = 1'b1;
      ST_IDLE:   cmd.capture  = s_tvalid;
      ST_READ:   cmd          = '0;
      ST_LOAD:   cmd.load     = 1'b1;
      ST_DIV:    cmd.step     = 1'b1;
      ST_FINISH: cmd.finish   = status.out_free;
      default:   cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      step_cnt <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (status.clear_done) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) state <= ST_READ;
        end
        ST_READ: state <= ST_LOAD;
        ST_LOAD: begin
          step_cnt <= '0;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == aem_pkg::StepCntW'(aem_pkg::DivSteps - 1)) state <= ST_FINISH;
        end
        ST_FINISH: begin
          // a finished tail returns to reset contents via a full clearing pass
          if (status.out_free) state <= status.last ? ST_CLEAR : ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  `AEM_ASSERT_NEXT(a_last_clears, clk, rst, cmd.finish && status.last, state == ST_CLEAR)
  `AEM_ASSERT_NEXT(a_accept_reads, clk, rst, s_tvalid && s_tready, state == ST_READ)
  `AEM_ASSERT_NOW(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd))

endmodule

@@ sv/aem_dp.sv @@
// datapath for the echo mixer: delay store, pointers, divider, mixer, output register
// depends on aem_pkg and audio_echo_mixer_top_defines.svh
`include "audio_echo_mixer_top_defines.svh"

module aem_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [aem_pkg::DivW-1:0]    cfg_data,
  input  logic [aem_pkg::SampleW-1:0] s_tdata,
  input  logic                        s_tuser,
  output logic [aem_pkg::SampleW-1:0] m_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic                        m_tlast,
  input  aem_pkg::cmd_t               cmd,
  output aem_pkg::status_t            status
);

  localparam int AW = aem_pkg::AddrW;
  localparam int DW = aem_pkg::DelayW;
  localparam int VW = aem_pkg::DivW;
  localparam int SW = aem_pkg::SampleW;

  logic [DW-1:0] delay_length;
  logic [VW-1:0] echo_divisor;
  logic [AW-1:0] write_position;
  logic [DW-1:0] tail_count;
  logic [AW-1:0] clr_addr;

  logic [SW-1:0] store [aem_pkg::MaxDelay];
  logic [SW-1:0] rd_data;

  logic          action;
  logic [SW-1:0] sample;
  logic [AW-1:0] idx;
  logic          neg;
  logic [VW-1:0] divisor;
  logic [VW:0]   rem;
  logic [VW-1:0] quo;

  logic [DW-1:0] eff_delay;
  logic [AW-1:0] idx_next;
  logic [DW-1:0] idx_inc;
  logic [AW-1:0] pos_next;
  logic [DW-1:0] tail_inc;
  logic [VW:0]   rem_shift;
  logic [VW+1:0] rem_diff;
  logic [SW:0]   echo;
  logic [SW+1:0] mix;
  logic [SW-1:0] result;
  logic [SW-1:0] rd_mag;

  // effective delay: zero acts as one, long values clamp to the store size
  always_comb begin
    if (delay_length == '0) begin
      eff_delay = DW'(1);
    end else if (delay_length > DW'(aem_pkg::MaxDelay)) begin
      eff_delay = DW'(aem_pkg::MaxDelay);
    end else begin
      eff_delay = delay_length;
    end
    idx_next = (DW'(write_position) < eff_delay) ? write_position : '0;
    idx_inc  = DW'(idx) + 1'b1;
    pos_next = (idx_inc >= eff_delay) ? '0 : idx_inc[AW-1:0];
    tail_inc = tail_count + 1'b1;
  end

  // divider step and mixing
  always_comb begin
    rem_shift = {rem[VW-1:0], quo[VW-1]};
    rem_diff  = {1'b0, rem_shift} - {2'b00, divisor};
    rd_mag    = rd_data[SW-1] ? (~rd_data + 1'b1) : rd_data;
    echo      = neg ? (~{1'b0, quo} + 1'b1) : {1'b0, quo};
    mix       = {{2{sample[SW-1]}}, sample} + {echo[SW], echo};
    if (action == aem_pkg::ActTail) begin
      result = echo[SW-1:0];
    end else if (!mix[SW+1] && mix[SW:SW-1] != 2'b00) begin
      result = {1'b0, {(SW-1){1'b1}}};
    end else if (mix[SW+1] && mix[SW:SW-1] != 2'b11) begin
      result = {1'b1, {(SW-1){1'b0}}};
    end else begin
      result = mix[SW-1:0];
    end
  end

  assign status.last       = (action == aem_pkg::ActTail) && (tail_inc >= eff_delay);
  assign status.out_free   = !m_tvalid || m_tready;
  assign status.clear_done = (clr_addr == {AW{1'b1}});

  // delay store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      store[clr_addr] <= '0;
    end else if (cmd.finish) begin
      store[idx] <= (action == aem_pkg::ActTail) ? '0 : sample;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= store[idx];
  end

  // control and configuration state
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length   <= aem_pkg::DelayReset;
      echo_divisor   <= aem_pkg::DivisorReset;
      write_position <= '0;
      tail_count     <= '0;
      clr_addr       <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          aem_pkg::CfgDelay:   delay_length <= cfg_data[DW-1:0];
          aem_pkg::CfgDivisor: echo_divisor <= cfg_data;
          default:             delay_length <= delay_length;
        endcase
      end
      if (cmd.clear_wr) clr_addr <= clr_addr + 1'b1;
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
        if (status.last) begin
          write_position <= '0;
          tail_count     <= '0;
        end else begin
          write_position <= pos_next;
          if (action == aem_pkg::ActTail) tail_count <= tail_inc;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action <= s_tuser;
      sample <= s_tdata;
      idx    <= idx_next;
    end
    if (cmd.load) begin
      neg     <= rd_data[SW-1];
      quo     <= rd_mag;
      rem     <= '0;
      divisor <= (echo_divisor == '0) ? VW'(1) : echo_divisor;
    end else if (cmd.step) begin
      if (!rem_diff[VW+1]) begin
        rem <= rem_diff[VW:0];
        quo <= {quo[VW-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[VW-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      m_tdata <= result;
      m_tlast <= status.last;
    end
  end

  `AEM_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.finish, status.out_free)
  `AEM_ASSERT_NEXT(a_last_resets, clk, rst, cmd.finish && status.last,
                   write_position == '0 && tail_count == '0)
  `AEM_ASSERT_NOW(a_tail_bound, clk, rst, 1'b1, tail_count < DW'(aem_pkg::MaxDelay))

endmodule
